/* sv/isort_pkg.sv */
// shared types for the insertion sorter
`default_nettype none

package isort_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic drain;
   } isort_ctl_type;

endpackage

`default_nettype wire

/* sv/isort_if.sv */
// request and response channel interfaces
`default_nettype none

interface isort_req_if
   import isort_pkg::*;
;
   logic     valid;
   logic     ready;
   data_type value;
   logic     final_req;

   modport source (output valid, output value, output final_req, input ready);
   modport sink (input valid, input value, input final_req, output ready);
endinterface

interface isort_rsp_if
   import isort_pkg::*;
;
   logic     valid;
   logic     ready;
   data_type sorted_value;
   logic     end_of_run;
   logic     overflowed;

   modport source (output valid, output sorted_value, output end_of_run,
                   output overflowed, input ready);
   modport sink (input valid, input sorted_value, input end_of_run,
                 input overflowed, output ready);
endinterface

`default_nettype wire

/* sv/insertion_sorter_unit.sv */
// insertion sorter: a row of cells that keeps an ascending set and drains it on the last request
// a non-final request is taken at one request per cycle while no run drains, and gives no response
// a final request is inserted in its cycle if the row has room; it sets the drain flag, and the
// head value then moves into the output stage; draining gives one result per cycle from the head
// cell while the output stage is free or taken; requests wait until the run is out
// synchronous active-high reset empties the row and clears the drain flag, overflow mark and output valid
`default_nettype none

module insertion_sorter_unit
   import isort_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   isort_req_if.sink   req,
   isort_rsp_if.source rsp
);

   // row of cells, index 0 holds the smallest value
   data_type      cell_data  [CAPACITY];
   logic          cell_valid [CAPACITY];
   logic          cell_gt    [CAPACITY];
   isort_ctl_type ctl;

   // control registers
   logic     draining_ff, draining_in;
   logic     dropped_ff, dropped_in;

   // output stage
   logic     rsp_valid_ff, rsp_valid_in;
   data_type rsp_value_ff, rsp_value_in;
   logic     rsp_last_ff, rsp_last_in;
   logic     rsp_ovf_ff, rsp_ovf_in;

   logic     req_take;
   logic     row_full;
   logic     drain_step;

   assign req.ready  = !draining_ff;
   assign req_take   = req.valid && req.ready;
   assign row_full   = cell_valid[CAPACITY-1];

   // head cell moves into the output stage when that stage is free or being emptied
   assign drain_step = draining_ff && (!rsp_valid_ff || rsp.ready);

   assign ctl.insert = req_take && !row_full;
   assign ctl.drain  = drain_step;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic     p_gt, p_valid, n_valid;
         data_type p_data, n_data;

         if (i == 0) begin : g_head
            // the head cell always sees an occupied, not-greater left side
            assign p_gt    = 1'b0;
            assign p_valid = 1'b1;
            assign p_data  = '0;
         end else begin : g_body
            assign p_gt    = cell_gt[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_data  = cell_data[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign n_valid = 1'b0;
            assign n_data  = '0;
         end else begin : g_link
            assign n_valid = cell_valid[i+1];
            assign n_data  = cell_data[i+1];
         end

         isort_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .ins_value  (req.value),
            .prev_gt    (p_gt),
            .prev_valid (p_valid),
            .prev_data  (p_data),
            .next_valid (n_valid),
            .next_data  (n_data),
            .gt_o       (cell_gt[i]),
            .valid_o    (cell_valid[i]),
            .data_o     (cell_data[i])
         );
      end
   endgenerate

   always_comb begin
      draining_in  = draining_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (req_take) begin
         // a request that meets a full row is lost, the set is marked
         if (row_full) begin
            dropped_in = 1'b1;
         end
         if (req.final_req) begin
            draining_in = 1'b1;
         end
      end

      if (drain_step) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = cell_data[0];
         rsp_last_in  = !cell_valid[1];
         rsp_ovf_in   = dropped_ff;
         if (!cell_valid[1]) begin
            // last element leaves, row is empty again
            draining_in = 1'b0;
            dropped_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff  <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         draining_ff  <= draining_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sorted_value = rsp_value_ff;
   assign rsp.end_of_run   = rsp_last_ff;
   assign rsp.overflowed   = rsp_ovf_ff;

endmodule

`default_nettype wire

/* sv/isort_cell.sv */
// one slot of the sorting row
`default_nettype none

module isort_cell
   import isort_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire isort_ctl_type ctl,
   input  wire data_type      ins_value,
   input  wire logic          prev_gt,
   input  wire logic          prev_valid,
   input  wire data_type      prev_data,
   input  wire logic          next_valid,
   input  wire data_type      next_data,
   output logic               gt_o,
   output logic               valid_o,
   output data_type           data_o
);

   data_type data_ff, data_in;
   logic     valid_ff, valid_in;

   assign gt_o    = valid_ff && (data_ff > ins_value);
   assign valid_o = valid_ff;
   assign data_o  = data_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctl.drain) begin
         data_in  = next_data;
         valid_in = next_valid;
      end else if (ctl.insert) begin
         // greater entries move up, the first greater or first empty slot takes the new value
         if (prev_gt) begin
            data_in = prev_data;
         end else if (gt_o || (!valid_ff && prev_valid)) begin
            data_in = ins_value;
         end
         valid_in = valid_ff | prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

/* sv/isort_checker.sv */
// port-level checks for the insertion sorter and their binding
`default_nettype none

module isort_checker
   import isort_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_ready,
   input wire logic     req_final_req,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire data_type rsp_sorted_value,
   input wire logic     rsp_end_of_run
);

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value))
      else $error("stalled response changed");

   // nothing is shown straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a final request closes the input until its run is out
   a_final_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_req |=> !req_ready)
      else $error("request taken right after a final request");

   // while a run is mid-way no request is taken
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_run |-> !req_ready)
      else $error("request ready in the middle of a run");

endmodule

bind insertion_sorter_unit isort_checker u_isort_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_final_req    (req.final_req),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_sorted_value (rsp.sorted_value),
   .rsp_end_of_run   (rsp.end_of_run)
);

`default_nettype wire

/* sim/insertion_sorter_unit_tb.sv */
// testbench for the insertion sorter: directed and random sets checked against a local sorter
`timescale 1ns / 100ps

module insertion_sorter_unit_tb
   import isort_pkg::*;
;

   localparam int SET_CAPACITY   = 16;
   localparam int TOTAL_REQUESTS = 280;
   localparam int CYCLE_LIMIT    = 100000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_LIMIT   = 10;

   // value mixes for the random sets
   typedef enum int unsigned {
      MIX_NARROW,
      MIX_EXTREME,
      MIX_WIDE
   } value_mix_type;

   // one expected response of the sorter
   typedef struct {
      data_type sorted_value;
      logic     end_of_run;
      logic     overflowed;
   } sort_result_type;

   // keeps its own ascending set and queues the run that each final request releases
   class sort_scoreboard;
      data_type        held[SET_CAPACITY];
      int unsigned     held_count;
      bit              lost_flag;
      sort_result_type expected_q[$];
      int unsigned     mismatches;
      int unsigned     checked;
      int unsigned     sets_closed;
      int unsigned     overflow_sets;

      function new();
         held_count    = 0;
         lost_flag     = 1'b0;
         mismatches    = 0;
         checked       = 0;
         sets_closed   = 0;
         overflow_sets = 0;
      endfunction

      function void note_request(data_type value, logic final_req);
         int unsigned     pos;
         sort_result_type entry;
         if (held_count >= SET_CAPACITY) begin
            lost_flag = 1'b1;
         end else begin
            // strictly greater entries move up, so equal values keep arrival order
            pos = held_count;
            while (pos > 0 && held[pos-1] > value) begin
               held[pos] = held[pos-1];
               pos--;
            end
            held[pos] = value;
            held_count++;
         end
         if (final_req) begin
            for (int k = 0; k < held_count; k++) begin
               entry.sorted_value = held[k];
               entry.end_of_run   = (k + 1 == held_count);
               entry.overflowed   = lost_flag;
               expected_q.push_back(entry);
            end
            sets_closed++;
            if (lost_flag)
               overflow_sets++;
            held_count = 0;
            lost_flag  = 1'b0;
         end
      endfunction

      function void check_result(data_type sorted_value, logic end_of_run, logic overflowed);
         sort_result_type entry;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: value %0d end %b ovf %b",
                        sorted_value, end_of_run, overflowed);
         end else begin
            entry = expected_q.pop_front();
            checked++;
            if (sorted_value !== entry.sorted_value || end_of_run !== entry.end_of_run ||
                overflowed !== entry.overflowed) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result mismatch: exp value %0d end %b ovf %b, got %0d end %b ovf %b",
                           entry.sorted_value, entry.end_of_run, entry.overflowed,
                           sorted_value, end_of_run, overflowed);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   isort_req_if req_ch ();
   isort_rsp_if rsp_ch ();

   sort_scoreboard sorter_check = new();

   // when set, neither side idles
   bit          calm_stretch = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned cycle_count = 0;

   insertion_sorter_unit #(
      .CAPACITY (SET_CAPACITY)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run guard: a hang anywhere ends the run as a failure
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
   end

   // response side: samples at the edge, then decides whether to stall the next cycle
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sorter_check.check_result(rsp_ch.sorted_value, rsp_ch.end_of_run,
                                      rsp_ch.overflowed);
         rsp_ch.ready <= calm_stretch || ($urandom_range(99) >= 17);
      end
   end

   // offer one request, with random idle cycles ahead of it, and hold it until taken
   task automatic send_request(input data_type value, input logic final_req);
      while (!calm_stretch && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.value     <= value;
      req_ch.final_req <= final_req;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      sorter_check.note_request(value, final_req);
      requests_sent++;
   endtask

   // sender holds off until every queued response has come back
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      while (sorter_check.pending() != 0)
         @(posedge clock);
   endtask

   function automatic data_type pick_value(value_mix_type mix);
      data_type extremes[5];
      extremes = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1};
      case (mix)
         // narrow band gives plenty of equal values
         MIX_NARROW: return data_type'(int'($urandom_range(8)) - 4);
         MIX_EXTREME: return extremes[$urandom_range(4)];
         default: return data_type'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned   set_len;
      int unsigned   set_index;
      value_mix_type mix;

      req_ch.valid     <= 1'b0;
      req_ch.value     <= '0;
      req_ch.final_req <= 1'b0;
      reset            <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single element set, most negative value
      send_request(32'sh8000_0000, 1'b1);

      // both extremes and the values around zero, arriving out of order
      send_request(32'sh7FFF_FFFF, 1'b0);
      send_request(32'sh8000_0000, 1'b0);
      send_request(32'sh0, 1'b0);
      send_request(-32'sd1, 1'b1);

      // full store: descending fill shifts every entry, then a dropped
      // non-final request and a dropped final request
      for (int i = 0; i < SET_CAPACITY; i++)
         send_request(data_type'(1000 - 37 * i), 1'b0);
      send_request(32'sh7FFF_FFFF, 1'b0);
      send_request(-32'sd7, 1'b1);

      // let the directed runs drain before the random part
      hold_until_drained();

      set_index = 0;
      while (requests_sent < TOTAL_REQUESTS) begin
         // mostly sets within capacity, now and then one that overflows
         if ($urandom_range(9) == 0)
            set_len = $urandom_range(SET_CAPACITY + 6, SET_CAPACITY + 1);
         else
            set_len = $urandom_range(SET_CAPACITY, 1);
         mix = value_mix_type'($urandom_range(3) > 2 ? MIX_WIDE : $urandom_range(2));
         calm_stretch = (set_index >= 4 && set_index < 10);
         for (int i = 0; i < set_len; i++)
            send_request(pick_value(mix), i == set_len - 1);
         if (set_index == 12)
            hold_until_drained();
         set_index++;
      end
      calm_stretch = 1'b0;
      req_ch.valid <= 1'b0;

      // wait for the last run, then watch a little longer for stray responses
      while (sorter_check.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests in %0d sets (%0d with overflow), %0d sorted results checked",
               requests_sent, sorter_check.sets_closed, sorter_check.overflow_sets,
               sorter_check.checked);
      $display("mismatches: %0d", sorter_check.mismatches);
      if (sorter_check.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
